// File: design/mocx_pkg.sv
// Shared types, codes and helper functions for the multi-order compare-exchange cell.
// No dependencies; every design file imports this package.
package mocx_pkg;

    // Ordering select codes
    localparam logic [2:0] MODE_JOIN_PREC  = 3'd0;
    localparam logic [2:0] MODE_PAIRWISE   = 3'd1;
    localparam logic [2:0] MODE_END_FIRST  = 3'd2;
    localparam logic [2:0] MODE_JOIN_INDEX = 3'd3;
    localparam logic [2:0] MODE_INDEX      = 3'd4;
    localparam logic [2:0] MODE_ALIGN      = 3'd5;

    // Entry kind codes
    localparam logic [1:0] KIND_SOURCE = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_OTHER  = 2'd3;

    // Precedence ranks among equal join attributes
    localparam logic [1:0] PREC_OTHER  = 2'd0;
    localparam logic [1:0] PREC_TIGHT  = 2'd1;
    localparam logic [1:0] PREC_SOURCE = 2'd2;
    localparam logic [1:0] PREC_LOOSE  = 2'd3;

    typedef struct packed {
        logic signed [31:0] first_join_attr;
        logic        [1:0]  first_kind;
        logic               first_is_eq;
        logic signed [31:0] first_index;
        logic signed [31:0] first_align_key;
        logic signed [31:0] second_join_attr;
        logic        [1:0]  second_kind;
        logic               second_is_eq;
        logic signed [31:0] second_index;
        logic signed [31:0] second_align_key;
    } in_item_t;

    typedef struct packed {
        logic               did_swap;
        logic signed [31:0] low_join_attr;
        logic        [1:0]  low_kind;
        logic               low_is_eq;
        logic signed [31:0] low_index;
        logic signed [31:0] low_align_key;
        logic signed [31:0] high_join_attr;
        logic        [1:0]  high_kind;
        logic               high_is_eq;
        logic signed [31:0] high_index;
        logic signed [31:0] high_align_key;
    } out_item_t;

    // Precedence of a (kind, equality) pair
    function automatic logic [1:0] kind_prec(input logic [1:0] kind, input logic is_eq);
        logic [1:0] p;
        begin
            case (kind)
                KIND_SOURCE: p = PREC_SOURCE;
                KIND_START:  p = is_eq ? PREC_TIGHT : PREC_LOOSE;
                KIND_END:    p = is_eq ? PREC_LOOSE : PREC_TIGHT;
                default:     p = PREC_OTHER;
            endcase
            return p;
        end
    endfunction

    // Kinds that are join targets (start or end)
    function automatic logic is_target(input logic [1:0] kind);
        return (kind == KIND_START) || (kind == KIND_END);
    endfunction

endpackage

// File: design/mocx_cmp.sv
// Combinational compare-exchange: decides the order of two entries under the
// selected mode and places them low/high. Depends on mocx_pkg.
module mocx_cmp (
    input  mocx_pkg::in_item_t  item,
    input  logic [2:0]          mode,
    output mocx_pkg::out_item_t result
);
    import mocx_pkg::*;

    logic       join_gt, join_eq;
    logic       index_gt, index_eq;
    logic       align_gt;
    logic [1:0] prec_a, prec_b;
    logic       tgt_a, tgt_b;
    logic       start_a, start_b, end_a, end_b;
    logic       swap;

    // Per-key signed compares
    assign join_gt  = item.first_join_attr > item.second_join_attr;
    assign join_eq  = item.first_join_attr == item.second_join_attr;
    assign index_gt = item.first_index > item.second_index;
    assign index_eq = item.first_index == item.second_index;
    assign align_gt = item.first_align_key > item.second_align_key;

    assign prec_a  = kind_prec(item.first_kind, item.first_is_eq);
    assign prec_b  = kind_prec(item.second_kind, item.second_is_eq);
    assign tgt_a   = is_target(item.first_kind);
    assign tgt_b   = is_target(item.second_kind);
    assign start_a = item.first_kind == KIND_START;
    assign start_b = item.second_kind == KIND_START;
    assign end_a   = item.first_kind == KIND_END;
    assign end_b   = item.second_kind == KIND_END;

    // Swap when first orders strictly after second
    always_comb
    begin
        case (mode)
            MODE_JOIN_PREC:  swap = join_gt || (join_eq && (prec_a > prec_b));
            MODE_PAIRWISE:   swap = (tgt_b && !tgt_a)
                                  || ((tgt_a == tgt_b)
                                      && (index_gt || (index_eq && start_b && !start_a)));
            MODE_END_FIRST:  swap = (end_b && !end_a) || ((end_a == end_b) && index_gt);
            MODE_JOIN_INDEX: swap = join_gt || (join_eq && index_gt);
            MODE_INDEX:      swap = index_gt;
            MODE_ALIGN:      swap = align_gt;
            default:         swap = 1'b0;
        endcase
    end

    // Place entries
    always_comb
    begin
        result.did_swap       = swap;
        result.low_join_attr  = swap ? item.second_join_attr : item.first_join_attr;
        result.low_kind       = swap ? item.second_kind      : item.first_kind;
        result.low_is_eq      = swap ? item.second_is_eq     : item.first_is_eq;
        result.low_index      = swap ? item.second_index     : item.first_index;
        result.low_align_key  = swap ? item.second_align_key : item.first_align_key;
        result.high_join_attr = swap ? item.first_join_attr  : item.second_join_attr;
        result.high_kind      = swap ? item.first_kind       : item.second_kind;
        result.high_is_eq     = swap ? item.first_is_eq      : item.second_is_eq;
        result.high_index     = swap ? item.first_index      : item.second_index;
        result.high_align_key = swap ? item.first_align_key  : item.second_align_key;
    end

endmodule

// File: design/multi_order_compare_exchange.sv
// Top level of the multi-order compare-exchange cell: input register, compare
// stage, result register and mode register. Depends on mocx_pkg and mocx_cmp.
//
// Usage:
//   in_valid/in_ready/in_data carry one item: the key fields of two entries.
//   out_valid/out_ready/out_data return the two entries in order plus did_swap,
//   which tells the caller to exchange the rest of the entry bytes.
//   cfg_we/cfg_data write order_mode (0..5; 6 and 7 pass items through unswapped).
//   Write the mode only while no item is in flight.
// Path: an accepted item enters the input register, then the result register, with
//   the compare logic between them; out_valid rises when the result register loads.
// Throughput: one item per cycle while out_ready is high; both registers advance
//   together when the receiver takes the result, so a full pipeline still accepts every cycle.
// Stall: while out_ready is low the result register holds; the input register
//   fills once more, then in_ready drops until the receiver takes the result.
// Reset: rst_n (async, active low) empties both stages and sets order_mode to 0.
module multi_order_compare_exchange (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  mocx_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mocx_pkg::out_item_t out_data
);
    import mocx_pkg::*;

    logic [2:0] mode_reg;
    logic       s1_valid_reg, s1_valid_next;
    in_item_t   s1_data_reg;
    logic       s2_valid_reg, s2_valid_next;
    out_item_t  s2_data_reg;
    out_item_t  cmp_result;
    logic       s1_load, s2_load;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_JOIN_PREC;
        else if (cfg_we)
            mode_reg <= cfg_data;
    end

    // Pipeline advance
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;
    assign s1_load  = in_valid && in_ready;

    assign s1_valid_next = s1_load || (s1_valid_reg && !s2_load);
    assign s2_valid_next = s2_load || (s2_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_data_reg <= in_data;
        if (s2_load)
            s2_data_reg <= cmp_result;
    end

    // Compare-exchange between the two registers
    mocx_cmp u_cmp (
        .item   (s1_data_reg),
        .mode   (mode_reg),
        .result (cmp_result)
    );

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

    // An accepted item always occupies the input stage next cycle
    a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_load |=> s1_valid_reg)
        else $error("accepted item lost from input stage");

    // Unused modes never swap
    a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_load && (mode_reg > MODE_ALIGN)) |=> !s2_data_reg.did_swap)
        else $error("swap under unused mode");

    // A swap needs entries that differ in some key
    a_swap_differs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.did_swap) |->
            (out_data.low_join_attr != out_data.high_join_attr)
            || (out_data.low_kind != out_data.high_kind)
            || (out_data.low_is_eq != out_data.high_is_eq)
            || (out_data.low_index != out_data.high_index)
            || (out_data.low_align_key != out_data.high_align_key))
        else $error("swap of equal entries");

    // Result register loads only from a full input stage
    a_s2_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!s2_valid_reg && !s1_valid_reg) |=> !s2_valid_reg)
        else $error("result stage filled from empty input stage");

endmodule

// File: dv/tb_multi_order_compare_exchange.sv
// Self-checking testbench for multi_order_compare_exchange: directed and random pairs
// under all eight order_mode codes, with a scoreboard class that predicts each exchange.
// Depends on mocx_pkg and the design top level only.
module tb_multi_order_compare_exchange;
    import mocx_pkg::*;

    // Codes with no ordering; the cell passes pairs through
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

    localparam int IDLE_PCT     = 14;
    localparam int HOLD_CYCLES  = 40;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 70;
    localparam int DRAIN_CYCLES = 8;

    // Tracks the predicted ordering of every accepted pair
    class exchange_tracker;
        logic [2:0] mode;
        out_item_t  expected_orders[$];
        int         mismatches;
        int         results_checked;
        int         swaps;

        function new();
            mode            = MODE_JOIN_PREC;
            mismatches      = 0;
            results_checked = 0;
            swaps           = 0;
        endfunction

        function int pending();
            return expected_orders.size();
        endfunction

        // Three-way signed compare: 1 when x sorts after y
        function int order_of(logic signed [31:0] x, logic signed [31:0] y);
            return (x > y) ? 1 : ((x < y) ? -1 : 0);
        endfunction

        // Rank among equal join attributes; other kinds rank lowest
        function logic [1:0] tie_rank(logic [1:0] kind, logic is_eq);
            case (kind)
                KIND_SOURCE: return PREC_SOURCE;
                KIND_START:  return is_eq ? PREC_TIGHT : PREC_LOOSE;
                KIND_END:    return is_eq ? PREC_LOOSE : PREC_TIGHT;
                default:     return PREC_OTHER;
            endcase
        endfunction

        function int join_target(logic [1:0] kind);
            return int'(kind == KIND_START || kind == KIND_END);
        endfunction

        function out_item_t predict_exchange(in_item_t it);
            out_item_t   res;
            logic [98:0] first_entry;
            logic [98:0] second_entry;
            int          ord;
            ord = 0;
            case (mode)
                MODE_JOIN_PREC: begin
                    ord = order_of(it.first_join_attr, it.second_join_attr);
                    if (ord == 0)
                        ord = order_of(32'(tie_rank(it.first_kind, it.first_is_eq)),
                                       32'(tie_rank(it.second_kind, it.second_is_eq)));
                end
                MODE_PAIRWISE: begin
                    ord = join_target(it.second_kind) - join_target(it.first_kind);
                    if (ord == 0)
                        ord = order_of(it.first_index, it.second_index);
                    if (ord == 0)
                        ord = int'(it.second_kind == KIND_START)
                            - int'(it.first_kind == KIND_START);
                end
                MODE_END_FIRST: begin
                    ord = int'(it.second_kind == KIND_END) - int'(it.first_kind == KIND_END);
                    if (ord == 0)
                        ord = order_of(it.first_index, it.second_index);
                end
                MODE_JOIN_INDEX: begin
                    ord = order_of(it.first_join_attr, it.second_join_attr);
                    if (ord == 0)
                        ord = order_of(it.first_index, it.second_index);
                end
                MODE_INDEX: ord = order_of(it.first_index, it.second_index);
                MODE_ALIGN: ord = order_of(it.first_align_key, it.second_align_key);
                default:    ord = 0;
            endcase
            // Both structs lay out an entry the same way, so whole entries move
            {first_entry, second_entry} = it;
            res = (ord > 0) ? {1'b1, second_entry, first_entry}
                            : {1'b0, first_entry, second_entry};
            return res;
        endfunction

        function void note_pair(in_item_t it);
            expected_orders.push_back(predict_exchange(it));
        endfunction

        task flag_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                flag_mismatch($sformatf("result %0d %s: got %h, want %h",
                                        results_checked, name, got, want));
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_orders.size() == 0) begin
                flag_mismatch("result with no pending item");
                return;
            end
            want = expected_orders.pop_front();
            results_checked++;
            if (want.did_swap)
                swaps++;
            check_field("did_swap",       32'(got.did_swap),   32'(want.did_swap));
            check_field("low_join_attr",  got.low_join_attr,   want.low_join_attr);
            check_field("low_kind",       32'(got.low_kind),   32'(want.low_kind));
            check_field("low_is_eq",      32'(got.low_is_eq),  32'(want.low_is_eq));
            check_field("low_index",      got.low_index,       want.low_index);
            check_field("low_align_key",  got.low_align_key,   want.low_align_key);
            check_field("high_join_attr", got.high_join_attr,  want.high_join_attr);
            check_field("high_kind",      32'(got.high_kind),  32'(want.high_kind));
            check_field("high_is_eq",     32'(got.high_is_eq), 32'(want.high_is_eq));
            check_field("high_index",     got.high_index,      want.high_index);
            check_field("high_align_key", got.high_align_key,  want.high_align_key);
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    logic [2:0] cfg_data;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    exchange_tracker sb = new();

    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;
    int items_sent = 0;
    int mode_writes = 0;

    multi_order_compare_exchange u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // Keys: small values (-3..3) four times in ten so ties reach the tie-break rules
    function automatic logic signed [31:0] rand_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom_range(0, 6) - 3;
        if (sel == 4) begin
            case ($urandom_range(0, 3))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.first_join_attr  = rand_key();
        it.first_kind       = 2'($urandom_range(0, 3));
        it.first_is_eq      = 1'($urandom_range(0, 1));
        it.first_index      = rand_key();
        it.first_align_key  = rand_key();
        it.second_join_attr = rand_key();
        it.second_kind      = 2'($urandom_range(0, 3));
        it.second_is_eq     = 1'($urandom_range(0, 1));
        it.second_index     = rand_key();
        it.second_align_key = rand_key();
        // Force exact ties now and then
        if ($urandom_range(0, 2) == 0) it.second_join_attr = it.first_join_attr;
        if ($urandom_range(0, 2) == 0) it.second_index     = it.first_index;
        if ($urandom_range(0, 2) == 0) it.second_align_key = it.first_align_key;
        if ($urandom_range(0, 3) == 0) it.second_kind      = it.first_kind;
        return it;
    endfunction

    // Extremes, signed overflow corners and fully tied keys
    function automatic in_item_t directed_item(input int k);
        in_item_t it;
        it = '0;
        case (k)
            0: begin
                it.first_join_attr  = KEY_MAX;  it.second_join_attr = KEY_MIN;
                it.first_index      = KEY_MAX;  it.second_index     = KEY_MIN;
                it.first_align_key  = KEY_MAX;  it.second_align_key = KEY_MIN;
                it.first_kind       = KIND_OTHER;  it.first_is_eq  = 1'b1;
                it.second_kind      = KIND_SOURCE; it.second_is_eq = 1'b0;
            end
            1: begin
                it.first_join_attr  = KEY_MIN;  it.second_join_attr = KEY_MAX;
                it.first_index      = KEY_MIN;  it.second_index     = KEY_MAX;
                it.first_align_key  = KEY_MIN;  it.second_align_key = KEY_MAX;
                it.first_kind       = KIND_START; it.first_is_eq  = 1'b0;
                it.second_kind      = KIND_END;   it.second_is_eq = 1'b1;
            end
            default: begin
                it.first_join_attr  = -1;  it.second_join_attr = -1;
                it.first_index      = -1;  it.second_index     = -1;
                it.first_align_key  = -1;  it.second_align_key = -1;
                it.first_kind       = KIND_START; it.first_is_eq  = 1'b0;
                it.second_kind      = KIND_END;   it.second_is_eq = 1'b0;
            end
        endcase
        return it;
    endfunction

    // Offer one item, with a random gap first; handshake sampled at negedge
    task automatic send_item(input in_item_t it);
        bit taken;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = (in_ready === 1'b1);
            @(posedge clk);
        end
        sb.note_pair(it);
        items_sent++;
    endtask

    // Mode write once every pending pair has come back
    task automatic set_mode(input logic [2:0] m);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.mode = m;
        mode_writes++;
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        int  hold_left;
        bit  rdy;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (no_idle)
                rdy = 1'b1;
            else
                rdy = ($urandom_range(0, 99) >= IDLE_PCT);
            out_ready <= rdy;
        end
    end

    // Result monitor: values at negedge are those seen by the next edge
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            sb.check_result(out_data);
    end

    // Stimulus
    initial
    begin
        logic [2:0] mode_order [8];
        int p;
        int n;
        int k;
        int m;
        mode_order = '{MODE_ALIGN, MODE_JOIN_PREC, MODE_JOIN_INDEX, MODE_PAIRWISE,
                       MODE_SPARE_HI, MODE_INDEX, MODE_END_FIRST, MODE_SPARE_LO};
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= MODE_JOIN_PREC;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners under every mode code
        for (m = 0; m < 8; m++) begin
            set_mode(3'(m));
            for (k = 0; k < 3; k++)
                send_item(directed_item(k));
        end

        // Random phases; one long receiver hold-off, one stretch with no gaps
        for (p = 0; p < PHASES; p++) begin
            set_mode((p < 8) ? mode_order[p] : 3'($urandom_range(0, 5)));
            no_idle = (p == 6);
            if (p == 4)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_item(rand_item());
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pairs across %0d mode writes covering all eight codes;",
                 items_sent, mode_writes);
        $display("checked %0d ordered results, %0d of them exchanged.",
                 sb.results_checked, sb.swaps);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
